[hw/rtl/fwso_pkg.sv]
// Package for four-wheel-steer odometry: widths, CORDIC constants, shared types.
// No dependencies.
`timescale 1ns / 1ps
package fwso_pkg;
    localparam int NUM_WHEELS = 4;
    localparam int CORDIC_STEPS = 16;
    localparam logic signed [31:0] CORDIC_START = 32'sd652032874;
    localparam int QUARTER = 16384;
    localparam logic [15:0] GAIN_RESET = 16'd9782;
    localparam logic signed [55:0] POS_MAX = {1'b0, {55{1'b1}}};
    localparam logic signed [55:0] POS_MIN = {1'b1, {55{1'b0}}};
    localparam logic [19:0] US_PER_S = 20'd1000000;

    typedef enum logic [2:0] {
        ST_IDLE, ST_LANES, ST_MEAN, ST_ROT, ST_ROT2, ST_SCALE, ST_DIV, ST_OUT
    } fwso_state_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } fwso_ctl_t;

    typedef struct packed {
        logic signed [15:0] wheel_speed_0;
        logic signed [15:0] wheel_speed_1;
        logic signed [15:0] wheel_speed_2;
        logic signed [15:0] wheel_speed_3;
        logic [11:0]        steer_raw_0;
        logic [11:0]        steer_raw_1;
        logic [11:0]        steer_raw_2;
        logic [11:0]        steer_raw_3;
        logic signed [15:0] heading_abs;
        logic [15:0]        tick_us;
    } tick_t;

    typedef struct packed {
        logic signed [55:0] pos_x;
        logic signed [55:0] pos_y;
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic signed [31:0] turn_rate;
        logic signed [15:0] heading_rel;
    } odom_t;

    function automatic logic signed [15:0] atan_entry(input logic [3:0] i);
        logic signed [15:0] r;
        begin
            case (i)
                4'd0: r = 16'sd8192;
                4'd1: r = 16'sd4836;
                4'd2: r = 16'sd2555;
                4'd3: r = 16'sd1297;
                4'd4: r = 16'sd651;
                4'd5: r = 16'sd326;
                4'd6: r = 16'sd163;
                4'd7: r = 16'sd81;
                4'd8: r = 16'sd41;
                4'd9: r = 16'sd20;
                4'd10: r = 16'sd10;
                4'd11: r = 16'sd5;
                4'd12: r = 16'sd3;
                4'd13: r = 16'sd1;
                4'd14: r = 16'sd1;
                default: r = 16'sd0;
            endcase
            return r;
        end
    endfunction
endpackage

[hw/rtl/fwso_if.sv]
// Valid/ready channel interface carrying a payload of type T.
// Depends on nothing.
`timescale 1ns / 1ps
interface fwso_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/fwso_cordic.sv]
// Iterative CORDIC: cosine and sine of a 16-bit binary angle, Q1.30, one step a cycle.
// Depends on fwso_pkg.
`timescale 1ns / 1ps
module fwso_cordic
    import fwso_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [15:0]        angle,
    output logic               done,
    output logic signed [31:0] cos_q,
    output logic signed [31:0] sin_q
);
    logic signed [32:0] x_reg, x_next, y_reg, y_next;
    logic signed [17:0] z_reg, z_next;
    logic               flip_reg, flip_next;
    logic [4:0]         step_reg, step_next;
    logic               run_reg, run_next;
    logic               done_reg, done_next;
    logic signed [17:0] za;
    logic signed [32:0] dx, dy;

    always_comb
    begin
        za = 18'(signed'(angle));
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        flip_next = flip_reg;
        step_next = step_reg;
        run_next = run_reg;
        done_next = 1'b0;
        dx = y_reg >>> step_reg[3:0];
        dy = x_reg >>> step_reg[3:0];
        if (start)
        begin
            x_next = 33'(CORDIC_START);
            y_next = '0;
            flip_next = 1'b0;
            z_next = za;
            if (za > 18'sd16384)
            begin
                z_next = za - 18'sd32768;
                flip_next = 1'b1;
            end
            else if (za < -18'sd16384)
            begin
                z_next = za + 18'sd32768;
                flip_next = 1'b1;
            end
            step_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (z_reg >= 0)
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - 18'(atan_entry(step_reg[3:0]));
            end
            else
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + 18'(atan_entry(step_reg[3:0]));
            end
            step_next = step_reg + 5'd1;
            if (step_reg == 5'(CORDIC_STEPS - 1))
            begin
                run_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        flip_reg <= flip_next;
    end

    assign done = done_reg;
    assign cos_q = flip_reg ? 32'(-x_reg) : 32'(x_reg);
    assign sin_q = flip_reg ? 32'(-y_reg) : 32'(y_reg);
endmodule

[hw/rtl/fwso_lane.sv]
// One wheel lane: steering count to angle, CORDIC, speed times cos/sin (Q.30 product).
// Depends on fwso_pkg and fwso_cordic.
`timescale 1ns / 1ps
module fwso_lane
    import fwso_pkg::*;
#(
    parameter int ANGLE_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  fwso_ctl_t          ctl,
    input  logic signed [15:0] speed,
    input  logic [11:0]        steer,
    output logic               done,
    output logic signed [47:0] prod_x,
    output logic signed [47:0] prod_y
);
    logic [ANGLE_BITS-1:0] ang_full;
    logic [15:0]           ang16;
    logic                  cdone;
    logic signed [31:0]    c, s;
    logic signed [47:0]    px_reg, py_reg;
    logic                  done_reg;

    assign ang_full = ANGLE_BITS'({~steer[11], steer[10:0]}) << (ANGLE_BITS - 12);
    generate
        if (ANGLE_BITS >= 16)
        begin : g_wide
            assign ang16 = 16'(ang_full >> (ANGLE_BITS - 16));
        end
        else
        begin : g_narrow
            assign ang16 = 16'(ang_full) << (16 - ANGLE_BITS);
        end
    endgenerate

    fwso_cordic u_cordic (
        .clk(clk), .rst_n(rst_n), .start(ctl.start), .angle(ang16),
        .done(cdone), .cos_q(c), .sin_q(s)
    );

    always_ff @(posedge clk)
    begin
        if (cdone)
        begin
            px_reg <= 48'(speed) * 48'(c);
            py_reg <= 48'(speed) * 48'(s);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cdone;
    end

    assign done = done_reg;
    assign prod_x = px_reg;
    assign prod_y = py_reg;
endmodule

[hw/rtl/fwso_div.sv]
// Serial signed divider: quotient truncated toward zero, one bit a cycle.
// Depends on fwso_pkg.
`timescale 1ns / 1ps
module fwso_div
    import fwso_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [35:0] dividend,
    input  logic [15:0]        divisor,
    output logic               done,
    output logic signed [35:0] quotient
);
    logic [35:0] q_reg, q_next;
    logic [16:0] r_reg, r_next;
    logic [15:0] d_reg, d_next;
    logic        neg_reg, neg_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next, done_reg, done_next;
    logic [16:0] trial;

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        run_next = run_reg;
        done_next = 1'b0;
        trial = {r_reg[15:0], q_reg[35]};
        if (start)
        begin
            neg_next = dividend[35];
            q_next = dividend[35] ? 36'(-dividend) : 36'(dividend);
            r_next = '0;
            d_next = divisor;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[34:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[34:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd35)
            begin
                run_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
        neg_reg <= neg_next;
    end

    assign done = done_reg;
    assign quotient = neg_reg ? 36'(-q_reg) : q_reg;
endmodule

[hw/rtl/four_wheel_steer_odometry.sv]
// Four-wheel-steer odometry top level: wheel lanes, merge, rotation, integration.
// Depends on fwso_pkg, fwso_if, fwso_lane, fwso_cordic, fwso_div.
// The two 16-step CORDIC passes (lanes, then heading) and the serial divider
// run in turn for each accepted transaction. A new transaction is accepted
// only in the idle state; a result waiting in the output register holds the
// state machine in its output state and so also stalls the input. Reset clears
// position and heading state and restores the gain.
`timescale 1ns / 1ps
module four_wheel_steer_odometry
    import fwso_pkg::*;
#(
    parameter int ANGLE_BITS = 16
)
(
    input  logic clk,
    input  logic rst_n,
    fwso_if.sink   in_ch,
    fwso_if.sink   cfg,
    fwso_if.source out_ch
);
    localparam int SUM_W = 48 + $clog2(NUM_WHEELS) + 1;

    fwso_state_t state_reg, state_next;
    logic [15:0] gain_reg;
    logic [15:0] hoff_reg, hlast_reg;
    logic        taken_reg;
    logic signed [55:0] posx_reg, posy_reg;
    logic signed [15:0] speed_reg [NUM_WHEELS];
    logic [11:0] steer_reg [NUM_WHEELS];
    logic [15:0] tick_reg, hrel_reg;
    logic signed [47:0] px [NUM_WHEELS];
    logic signed [47:0] py [NUM_WHEELS];
    logic [NUM_WHEELS-1:0] ldone;
    logic signed [SUM_W-1:0] sumx, sumy;
    logic signed [25:0] mx_reg, my_reg;
    logic signed [31:0] hc, hs;
    logic hdone;
    logic signed [57:0] m1_reg, m2_reg, m3_reg, m4_reg;
    logic signed [35:0] rx_reg, ry_reg;
    logic signed [15:0] vx_reg, vy_reg;
    logic signed [31:0] rate_reg;
    logic out_valid_reg;
    odom_t out_data_reg;
    logic out_load;
    logic div_start, div_done;
    logic signed [35:0] quo;
    logic signed [15:0] delta;
    logic in_fire;
    logic signed [52:0] gx, gy;
    logic signed [57:0] nx, ny;

    assign in_fire = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign cfg.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_fire) state_next = ST_LANES;
            ST_LANES: if (ldone[0]) state_next = ST_MEAN;
            ST_MEAN:  state_next = ST_ROT;
            ST_ROT:   if (hdone) state_next = ST_ROT2;
            ST_ROT2:  state_next = ST_SCALE;
            ST_SCALE: state_next = ST_DIV;
            ST_DIV:   if (div_done) state_next = ST_OUT;
            ST_OUT:   if (!out_valid_reg || out_ch.ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || out_ch.ready);

    logic lanes_started_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lanes_started_reg <= 1'b0;
        else
            lanes_started_reg <= (state_reg == ST_IDLE) && in_fire;
    end

    fwso_ctl_t lctl;
    assign lctl = '{start: lanes_started_reg, busy: state_reg != ST_IDLE, done: ldone[0]};

    genvar g;
    generate
        for (g = 0; g < NUM_WHEELS; g++)
        begin : g_lane
            fwso_lane #(.ANGLE_BITS(ANGLE_BITS)) u_lane (
                .clk(clk), .rst_n(rst_n), .ctl(lctl), .speed(speed_reg[g]),
                .steer(steer_reg[g]), .done(ldone[g]), .prod_x(px[g]), .prod_y(py[g])
            );
        end
    endgenerate

    always_comb
    begin
        sumx = '0;
        sumy = '0;
        for (int i = 0; i < NUM_WHEELS; i++)
        begin
            sumx = sumx + SUM_W'(px[i]);
            sumy = sumy + SUM_W'(py[i]);
        end
    end

    logic signed [SUM_W-1:0] qx, qy;
    assign qx = sumx / NUM_WHEELS;
    assign qy = sumy / NUM_WHEELS;

    fwso_cordic u_head (
        .clk(clk), .rst_n(rst_n), .start(state_reg == ST_MEAN), .angle(hrel_reg),
        .done(hdone), .cos_q(hc), .sin_q(hs)
    );

    assign delta = 16'(hrel_reg - hlast_reg);
    assign div_start = (state_reg == ST_SCALE);
    fwso_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .dividend(36'(delta) * 36'(signed'({1'b0, US_PER_S}))),
        .divisor(tick_reg), .done(div_done), .quotient(quo)
    );

    assign gx = 53'(rx_reg) * 53'(signed'({1'b0, gain_reg}));
    assign gy = 53'(ry_reg) * 53'(signed'({1'b0, gain_reg}));
    logic signed [20:0] vxw, vyw;
    assign vxw = 21'(gx >>> 32);
    assign vyw = 21'(gy >>> 32);
    assign nx = 58'(posx_reg) + 58'(vx_reg) * 58'(signed'({1'b0, tick_reg}));
    assign ny = 58'(posy_reg) + 58'(vy_reg) * 58'(signed'({1'b0, tick_reg}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            gain_reg <= GAIN_RESET;
            hoff_reg <= '0;
            hlast_reg <= '0;
            taken_reg <= 1'b0;
            posx_reg <= '0;
            posy_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid && cfg.ready)
                gain_reg <= cfg.data;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
            if (in_fire && !taken_reg)
            begin
                hoff_reg <= in_ch.data.heading_abs;
                taken_reg <= 1'b1;
            end
            if (state_reg == ST_DIV && div_done)
            begin
                hlast_reg <= hrel_reg;
                posx_reg <= (nx > 58'(POS_MAX)) ? POS_MAX :
                            (nx < 58'(POS_MIN)) ? POS_MIN : 56'(nx);
                posy_reg <= (ny > 58'(POS_MAX)) ? POS_MAX :
                            (ny < 58'(POS_MIN)) ? POS_MIN : 56'(ny);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            speed_reg[0] <= in_ch.data.wheel_speed_0;
            speed_reg[1] <= in_ch.data.wheel_speed_1;
            speed_reg[2] <= in_ch.data.wheel_speed_2;
            speed_reg[3] <= in_ch.data.wheel_speed_3;
            steer_reg[0] <= in_ch.data.steer_raw_0;
            steer_reg[1] <= in_ch.data.steer_raw_1;
            steer_reg[2] <= in_ch.data.steer_raw_2;
            steer_reg[3] <= in_ch.data.steer_raw_3;
            tick_reg <= in_ch.data.tick_us;
            hrel_reg <= taken_reg ? 16'(in_ch.data.heading_abs - hoff_reg) : 16'd0;
        end
        if (state_reg == ST_MEAN)
        begin
            mx_reg <= 26'(qx >>> 22);
            my_reg <= 26'(qy >>> 22);
        end
        if (state_reg == ST_ROT && hdone)
        begin
            m1_reg <= 58'(mx_reg) * 58'(hc);
            m2_reg <= 58'(my_reg) * 58'(hs);
            m3_reg <= 58'(mx_reg) * 58'(hs);
            m4_reg <= 58'(my_reg) * 58'(hc);
        end
        if (state_reg == ST_ROT2)
        begin
            rx_reg <= 36'((m1_reg - m2_reg) >>> 22);
            ry_reg <= 36'((m3_reg + m4_reg) >>> 22);
        end
        if (state_reg == ST_SCALE)
        begin
            vx_reg <= (vxw > 21'sd32767) ? 16'sh7FFF :
                      (vxw < -21'sd32768) ? 16'sh8000 : 16'(vxw);
            vy_reg <= (vyw > 21'sd32767) ? 16'sh7FFF :
                      (vyw < -21'sd32768) ? 16'sh8000 : 16'(vyw);
        end
        if (state_reg == ST_DIV && div_done)
        begin
            rate_reg <= (tick_reg == 16'd0) ? 32'sd0 :
                        (quo > 36'sd2147483647) ? 32'sh7FFFFFFF :
                        (quo < -36'sd2147483648) ? 32'sh80000000 : 32'(quo);
        end
        if (out_load)
        begin
            out_data_reg <= '{pos_x: posx_reg, pos_y: posy_reg, vel_x: vx_reg,
                              vel_y: vy_reg, turn_rate: rate_reg, heading_rel: hrel_reg};
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data = out_data_reg;

    a_lanes_together: assert property (@(posedge clk) disable iff (!rst_n)
        ldone[0] |-> ldone == {NUM_WHEELS{1'b1}})
        else $error("lanes finished out of step");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ch.ready)
        else $error("input accepted mid transaction");
    a_out_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_OUT)
        else $error("result without completed transaction");
endmodule
